// ----- design/fbnp_pkg.sv -----
`timescale 1ns / 1ps
// Package for file_block_to_node_path: tree geometry constants and result type.
// No dependencies.
package fbnp_pkg;

   localparam int BLK_W  = 30;
   localparam int CALC_W = 32;

   localparam logic [CALC_W-1:0] DIRECT_IN_INODE = 32'd256;
   localparam logic [CALC_W-1:0] ADDRS_PER_NODE  = 32'd512;
   localparam logic [CALC_W-1:0] NIDS_PER_NODE   = 32'd1024;
   localparam logic [CALC_W-1:0] FIRST_NODE_SLOT = 32'd257;

   localparam logic [CALC_W-1:0] IND_SPAN  = ADDRS_PER_NODE * NIDS_PER_NODE;
   localparam logic [CALC_W-1:0] DIND_SPAN = IND_SPAN * NIDS_PER_NODE;

   // region start bounds, cumulative
   localparam logic [CALC_W-1:0] DIR1_BASE = DIRECT_IN_INODE;
   localparam logic [CALC_W-1:0] DIR2_BASE = DIR1_BASE + ADDRS_PER_NODE;
   localparam logic [CALC_W-1:0] IND1_BASE = DIR2_BASE + ADDRS_PER_NODE;
   localparam logic [CALC_W-1:0] IND2_BASE = IND1_BASE + IND_SPAN;
   localparam logic [CALC_W-1:0] DIND_BASE = IND2_BASE + IND_SPAN;
   localparam logic [CALC_W-1:0] END_BASE  = DIND_BASE + DIND_SPAN;

   localparam logic [1:0] LVL_INODE  = 2'd0;
   localparam logic [1:0] LVL_DIRECT = 2'd1;
   localparam logic [1:0] LVL_IND    = 2'd2;
   localparam logic [1:0] LVL_DIND   = 2'd3;

   typedef struct packed {
      logic [1:0]  tree_level;
      logic [8:0]  slot_in_inode;
      logic [9:0]  offset_level_one;
      logic [9:0]  offset_level_two;
      logic [8:0]  offset_level_three;
      logic [11:0] node_ofs_one;
      logic [20:0] node_ofs_two;
      logic [20:0] node_ofs_three;
      logic        out_of_range;
   } rsp_type;

endpackage

// ----- design/file_block_to_node_path.sv -----
`timescale 1ns / 1ps
// file_block_to_node_path: maps a file block number to its node-tree path.
// An accepted request is captured in the input register; rsp_valid and the path come from the result register.
// Throughput: one item per cycle; busy is never raised.
// The input register feeds one pass of compare/subtract/shift logic into the result register.
// Reset (synchronous, active high) clears the valid flags only; payload is not reset.
// Depends on fbnp_pkg.
module file_block_to_node_path (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [29:0] req_block_number,
   output logic        rsp_valid,
   output logic [1:0]  rsp_tree_level,
   output logic [8:0]  rsp_slot_in_inode,
   output logic [9:0]  rsp_offset_level_one,
   output logic [9:0]  rsp_offset_level_two,
   output logic [8:0]  rsp_offset_level_three,
   output logic [11:0] rsp_node_ofs_one,
   output logic [20:0] rsp_node_ofs_two,
   output logic [20:0] rsp_node_ofs_three,
   output logic        rsp_out_of_range
);
   import fbnp_pkg::*;

   logic             in_valid_ff;
   logic [BLK_W-1:0] blk_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic [CALC_W-1:0] b;
   logic [CALC_W-1:0] rel;
   logic [CALC_W-1:0] o1;
   logic [CALC_W-1:0] o2;
   logic [CALC_W-1:0] o3;
   logic [CALC_W-1:0] n1;
   logic [CALC_W-1:0] n2;
   logic [CALC_W-1:0] n3;
   logic [CALC_W-1:0] slot;
   logic [1:0]        lvl;
   logic              oor;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start & ~busy;
         rsp_valid_ff <= in_valid_ff;
      end
      if (start & ~busy) begin
         blk_ff <= req_block_number;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      b    = {{(CALC_W-BLK_W){1'b0}}, blk_ff};
      rel  = '0;
      lvl  = LVL_INODE;
      slot = '0;
      o1   = '0;
      o2   = '0;
      o3   = '0;
      n1   = '0;
      n2   = '0;
      n3   = '0;
      oor  = 1'b0;
      priority if (b < DIR1_BASE) begin
         slot = b;
      end else if (b < DIR2_BASE) begin
         rel  = b - DIR1_BASE;
         lvl  = LVL_DIRECT;
         slot = FIRST_NODE_SLOT;
         n1   = 32'd1;
         o1   = rel;
      end else if (b < IND1_BASE) begin
         rel  = b - DIR2_BASE;
         lvl  = LVL_DIRECT;
         slot = FIRST_NODE_SLOT + 32'd1;
         n1   = 32'd2;
         o1   = rel;
      end else if (b < IND2_BASE) begin
         rel  = b - IND1_BASE;
         lvl  = LVL_IND;
         slot = FIRST_NODE_SLOT + 32'd2;
         n1   = 32'd3;
         o1   = rel / ADDRS_PER_NODE;
         n2   = 32'd4 + o1;
         o2   = rel % ADDRS_PER_NODE;
      end else if (b < DIND_BASE) begin
         rel  = b - IND2_BASE;
         lvl  = LVL_IND;
         slot = FIRST_NODE_SLOT + 32'd3;
         n1   = 32'd4 + NIDS_PER_NODE;
         o1   = rel / ADDRS_PER_NODE;
         n2   = 32'd5 + NIDS_PER_NODE + o1;
         o2   = rel % ADDRS_PER_NODE;
      end else if (b < END_BASE) begin
         rel  = b - DIND_BASE;
         lvl  = LVL_DIND;
         slot = FIRST_NODE_SLOT + 32'd4;
         n1   = 32'd5 + 32'd2 * NIDS_PER_NODE;
         o1   = rel / IND_SPAN;
         o2   = (rel / ADDRS_PER_NODE) % NIDS_PER_NODE;
         o3   = rel % ADDRS_PER_NODE;
         n2   = 32'd6 + 32'd2 * NIDS_PER_NODE + o1 * (NIDS_PER_NODE + 32'd1);
         n3   = 32'd7 + 32'd2 * NIDS_PER_NODE + o1 * (NIDS_PER_NODE + 32'd1) + o2;
      end else begin
         oor  = 1'b1;
      end
      rsp_in.tree_level         = lvl;
      rsp_in.slot_in_inode      = slot[8:0];
      rsp_in.offset_level_one   = o1[9:0];
      rsp_in.offset_level_two   = o2[9:0];
      rsp_in.offset_level_three = o3[8:0];
      rsp_in.node_ofs_one       = n1[11:0];
      rsp_in.node_ofs_two       = n2[20:0];
      rsp_in.node_ofs_three     = n3[20:0];
      rsp_in.out_of_range       = oor;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_tree_level         = rsp_ff.tree_level;
   assign rsp_slot_in_inode      = rsp_ff.slot_in_inode;
   assign rsp_offset_level_one   = rsp_ff.offset_level_one;
   assign rsp_offset_level_two   = rsp_ff.offset_level_two;
   assign rsp_offset_level_three = rsp_ff.offset_level_three;
   assign rsp_node_ofs_one       = rsp_ff.node_ofs_one;
   assign rsp_node_ofs_two       = rsp_ff.node_ofs_two;
   assign rsp_node_ofs_three     = rsp_ff.node_ofs_three;
   assign rsp_out_of_range       = rsp_ff.out_of_range;

   a_two_cycle_latency: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_valid)
      else $error("accepted item not answered two cycles later");

   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_tree_level == LVL_INODE && rsp_slot_in_inode == 9'd0 &&
         rsp_node_ofs_one == 12'd0)
      else $error("out-of-range result carries path data");

   a_inode_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tree_level == LVL_INODE |->
         rsp_node_ofs_one == 12'd0 && rsp_offset_level_one == 10'd0)
      else $error("inode-level result has child node data");

   a_level3_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tree_level != LVL_DIND |->
         rsp_node_ofs_three == 21'd0 && rsp_offset_level_three == 9'd0)
      else $error("third-level fields set on a shallower path");

endmodule

// ----- verif/fbnp_checker.sv -----
`timescale 1ns / 1ps
// Checker for file_block_to_node_path: watches the lookup and path channels,
// predicts each node path and compares it field by field. Depends on fbnp_pkg.
module fbnp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [29:0] req_block_number,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_tree_level,
   input  logic [8:0]  rsp_slot_in_inode,
   input  logic [9:0]  rsp_offset_level_one,
   input  logic [9:0]  rsp_offset_level_two,
   input  logic [8:0]  rsp_offset_level_three,
   input  logic [11:0] rsp_node_ofs_one,
   input  logic [20:0] rsp_node_ofs_two,
   input  logic [20:0] rsp_node_ofs_three,
   input  logic        rsp_out_of_range,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          inode_hits,
   output int          direct_hits,
   output int          ind_hits,
   output int          dind_hits,
   output int          oor_hits
);
   import fbnp_pkg::*;

   typedef struct packed {
      logic [29:0] blk;
      rsp_type     path;
   } lookup_type;

   lookup_type path_q [$];

   function automatic rsp_type node_path_of(input logic [29:0] blk);
      rsp_type     p;
      logic [31:0] rel, slot, o1, o2, o3, n1, n2, n3;
      logic [1:0]  lvl;
      logic        oor;
      rel  = {2'b00, blk};
      lvl  = LVL_INODE;
      oor  = 1'b0;
      slot = '0; o1 = '0; o2 = '0; o3 = '0; n1 = '0; n2 = '0; n3 = '0;
      if (rel < DIRECT_IN_INODE) begin
         slot = rel;
      end else begin
         rel = rel - DIRECT_IN_INODE;
         if (rel < ADDRS_PER_NODE) begin
            lvl  = LVL_DIRECT;
            slot = FIRST_NODE_SLOT;
            n1   = 32'd1;
            o1   = rel;
         end else if (rel - ADDRS_PER_NODE < ADDRS_PER_NODE) begin
            lvl  = LVL_DIRECT;
            slot = FIRST_NODE_SLOT + 32'd1;
            n1   = 32'd2;
            o1   = rel - ADDRS_PER_NODE;
         end else begin
            rel = rel - 2 * ADDRS_PER_NODE;
            if (rel < IND_SPAN) begin
               lvl  = LVL_IND;
               slot = FIRST_NODE_SLOT + 32'd2;
               n1   = 32'd3;
               o1   = rel / ADDRS_PER_NODE;
               n2   = 32'd4 + o1;
               o2   = rel % ADDRS_PER_NODE;
            end else if (rel - IND_SPAN < IND_SPAN) begin
               rel  = rel - IND_SPAN;
               lvl  = LVL_IND;
               slot = FIRST_NODE_SLOT + 32'd3;
               n1   = 32'd4 + NIDS_PER_NODE;
               o1   = rel / ADDRS_PER_NODE;
               n2   = 32'd5 + NIDS_PER_NODE + o1;
               o2   = rel % ADDRS_PER_NODE;
            end else begin
               rel = rel - 2 * IND_SPAN;
               if (rel < DIND_SPAN) begin
                  lvl  = LVL_DIND;
                  slot = FIRST_NODE_SLOT + 32'd4;
                  n1   = 32'd5 + 2 * NIDS_PER_NODE;
                  o1   = rel / IND_SPAN;
                  n2   = 32'd6 + 2 * NIDS_PER_NODE + o1 * (NIDS_PER_NODE + 32'd1);
                  o2   = (rel / ADDRS_PER_NODE) % NIDS_PER_NODE;
                  n3   = 32'd7 + 2 * NIDS_PER_NODE + o1 * (NIDS_PER_NODE + 32'd1) + o2;
                  o3   = rel % ADDRS_PER_NODE;
               end else begin
                  oor = 1'b1;
               end
            end
         end
      end
      p.tree_level         = lvl;
      p.slot_in_inode      = slot[8:0];
      p.offset_level_one   = o1[9:0];
      p.offset_level_two   = o2[9:0];
      p.offset_level_three = o3[8:0];
      p.node_ofs_one       = n1[11:0];
      p.node_ofs_two       = n2[20:0];
      p.node_ofs_three     = n3[20:0];
      p.out_of_range       = oor;
      return p;
   endfunction

   function automatic string path_text(input rsp_type p);
      return $sformatf("lvl=%0d slot=%0d o1=%0d o2=%0d o3=%0d n1=%0d n2=%0d n3=%0d oor=%0d",
                       p.tree_level, p.slot_in_inode, p.offset_level_one,
                       p.offset_level_two, p.offset_level_three, p.node_ofs_one,
                       p.node_ofs_two, p.node_ofs_three, p.out_of_range);
   endfunction

   always @(posedge clock) begin
      rsp_type    seen;
      lookup_type want;
      seen.tree_level         = rsp_tree_level;
      seen.slot_in_inode      = rsp_slot_in_inode;
      seen.offset_level_one   = rsp_offset_level_one;
      seen.offset_level_two   = rsp_offset_level_two;
      seen.offset_level_three = rsp_offset_level_three;
      seen.node_ofs_one       = rsp_node_ofs_one;
      seen.node_ofs_two       = rsp_node_ofs_two;
      seen.node_ofs_three     = rsp_node_ofs_three;
      seen.out_of_range       = rsp_out_of_range;
      if (!reset) begin
         if (rsp_valid) begin
            if (path_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("ERROR: path with no lookup pending: %s", path_text(seen));
            end else begin
               want = path_q.pop_front();
               checked <= checked + 1;
               if (want.path != seen) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("ERROR: block %0d", want.blk);
                     $display("   expected %s", path_text(want.path));
                     $display("   actual   %s", path_text(seen));
                  end
               end
               if (want.path.out_of_range)
                  oor_hits <= oor_hits + 1;
               else if (want.path.tree_level == LVL_INODE)
                  inode_hits <= inode_hits + 1;
               else if (want.path.tree_level == LVL_DIRECT)
                  direct_hits <= direct_hits + 1;
               else if (want.path.tree_level == LVL_IND)
                  ind_hits <= ind_hits + 1;
               else
                  dind_hits <= dind_hits + 1;
            end
         end
         if (start && !busy) begin
            want.blk  = req_block_number;
            want.path = node_path_of(req_block_number);
            path_q.push_back(want);
         end
      end
      pending <= path_q.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for file_block_to_node_path: drives directed and random block
// lookups with random gaps and gives the verdict. Depends on fbnp_pkg, fbnp_checker.
module tb;
   import fbnp_pkg::*;

   localparam int N_RANDOM    = 1200;
   localparam int CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [29:0] req_block_number = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_tree_level;
   logic [8:0]  rsp_slot_in_inode;
   logic [9:0]  rsp_offset_level_one;
   logic [9:0]  rsp_offset_level_two;
   logic [8:0]  rsp_offset_level_three;
   logic [11:0] rsp_node_ofs_one;
   logic [20:0] rsp_node_ofs_two;
   logic [20:0] rsp_node_ofs_three;
   logic        rsp_out_of_range;

   int fail_count, pending, checked;
   int inode_hits, direct_hits, ind_hits, dind_hits, oor_hits;
   int cycles = 0;
   int steady_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   file_block_to_node_path dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_block_number       (req_block_number),
      .rsp_valid              (rsp_valid),
      .rsp_tree_level         (rsp_tree_level),
      .rsp_slot_in_inode      (rsp_slot_in_inode),
      .rsp_offset_level_one   (rsp_offset_level_one),
      .rsp_offset_level_two   (rsp_offset_level_two),
      .rsp_offset_level_three (rsp_offset_level_three),
      .rsp_node_ofs_one       (rsp_node_ofs_one),
      .rsp_node_ofs_two       (rsp_node_ofs_two),
      .rsp_node_ofs_three     (rsp_node_ofs_three),
      .rsp_out_of_range       (rsp_out_of_range)
   );

   fbnp_checker chk (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_block_number       (req_block_number),
      .rsp_valid              (rsp_valid),
      .rsp_tree_level         (rsp_tree_level),
      .rsp_slot_in_inode      (rsp_slot_in_inode),
      .rsp_offset_level_one   (rsp_offset_level_one),
      .rsp_offset_level_two   (rsp_offset_level_two),
      .rsp_offset_level_three (rsp_offset_level_three),
      .rsp_node_ofs_one       (rsp_node_ofs_one),
      .rsp_node_ofs_two       (rsp_node_ofs_two),
      .rsp_node_ofs_three     (rsp_node_ofs_three),
      .rsp_out_of_range       (rsp_out_of_range),
      .fail_count             (fail_count),
      .pending                (pending),
      .checked                (checked),
      .inode_hits             (inode_hits),
      .direct_hits            (direct_hits),
      .ind_hits               (ind_hits),
      .dind_hits              (dind_hits),
      .oor_hits               (oor_hits)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_lookup(input logic [29:0] blk);
      start            <= 1'b1;
      req_block_number <= blk;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         start            <= 1'b0;
         req_block_number <= 30'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   // mostly short gaps, a few long ones, with stretches of back-to-back items
   function automatic int gap_len();
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         steady_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // region-weighted block number; offsets often hug the region edges
   function automatic logic [29:0] pick_block();
      logic [31:0] base, span, ofs;
      int          r;
      r = $urandom_range(0, 19);
      case (r)
         0, 1:    begin base = '0;        span = DIR1_BASE; end
         2, 3:    begin base = DIR1_BASE; span = ADDRS_PER_NODE; end
         4, 5:    begin base = DIR2_BASE; span = ADDRS_PER_NODE; end
         6, 7, 8: begin base = IND1_BASE; span = IND_SPAN; end
         9, 10, 11: begin base = IND2_BASE; span = IND_SPAN; end
         12, 13, 14, 15, 16: begin base = DIND_BASE; span = DIND_SPAN; end
         17:      begin base = END_BASE;  span = 32'h4000_0000 - END_BASE; end
         default: begin base = '0;        span = 32'h4000_0000; end
      endcase
      case ($urandom_range(0, 7))
         0:       ofs = $urandom_range(0, 3);
         1:       ofs = span - 1 - $urandom_range(0, 3);
         default: ofs = $urandom_range(0, span - 1);
      endcase
      return 30'(base + ofs);
   endfunction

   initial begin
      logic [31:0] corner [$];
      corner = {32'd0, 32'd1, DIR1_BASE - 1, DIR1_BASE, DIR2_BASE - 1, DIR2_BASE,
                IND1_BASE - 1, IND1_BASE, IND1_BASE + ADDRS_PER_NODE,
                IND2_BASE - 1, IND2_BASE, IND2_BASE + IND_SPAN / 2,
                DIND_BASE - 1, DIND_BASE, DIND_BASE + ADDRS_PER_NODE,
                DIND_BASE + IND_SPAN - 1, DIND_BASE + IND_SPAN,
                END_BASE - 1, END_BASE, 32'h3FFF_FFFF, 32'h2AAA_AAAA, 32'h1555_5555};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      foreach (corner[i]) send_lookup(30'(corner[i]));
      hold_off(3);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_lookup(pick_block());
         hold_off(gap_len());
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("checked %0d lookups: %0d inode, %0d direct, %0d indirect,", checked,
               inode_hits, direct_hits, ind_hits);
      $display("   %0d double indirect, %0d out of range; %0d errors, %0d left pending",
               dind_hits, oor_hits, fail_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
